FILE: hw/rtl/hrlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlp_pkg: shared types and constants of the request line parser
// Request and result payloads, the front-to-back packet and the result kinds.
// ----------------------------------------------------------------------------
package hrlp_pkg;

  // Default field capacities (a field keeps capacity - 1 characters)
  localparam int HRLP_METHOD_CAP   = 16;
  localparam int HRLP_TARGET_CAP   = 128;
  localparam int HRLP_PROTOCOL_CAP = 16;
  localparam int HRLP_QUEUE_DEPTH  = 4;

  // Result kinds
  localparam logic [2:0] KIND_METHOD   = 3'd0;
  localparam logic [2:0] KIND_TARGET   = 3'd1;
  localparam logic [2:0] KIND_PROTOCOL = 3'd2;
  localparam logic [2:0] KIND_VERSION  = 3'd3;
  localparam logic [2:0] KIND_BLANK    = 3'd4;
  localparam logic [2:0] KIND_END      = 3'd5;

  // Characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // One input byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       final_byte;
  } hrlp_req_t;

  // One result
  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] position;
    logic [7:0] char_out;
    logic [7:0] version_major;
    logic [3:0] version_tenths;
    logic       last;
  } hrlp_res_t;

  // Everything one byte causes: an optional main result, then an optional
  // text-ended result. The character is raw; back lower-cases method, protocol.
  typedef struct packed {
    logic       has_main;
    logic       has_end;
    logic [2:0] kind;
    logic [6:0] position;
    logic [7:0] char_raw;
    logic [7:0] major;
    logic [3:0] tenths;
  } hrlp_pkt_t;

endpackage

FILE: hw/rtl/hrlp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlp_front: byte classifier and parse state
// Updates the parse state once per accepted byte and builds the packet of
// results that the byte causes.
// ----------------------------------------------------------------------------
module hrlp_front #(
  parameter int METHOD_CAPACITY   = hrlp_pkg::HRLP_METHOD_CAP,
  parameter int TARGET_CAPACITY   = hrlp_pkg::HRLP_TARGET_CAP,
  parameter int PROTOCOL_CAPACITY = hrlp_pkg::HRLP_PROTOCOL_CAP
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  hrlp_pkg::hrlp_req_t req_i,
  output logic              enq_o,
  output hrlp_pkg::hrlp_pkt_t pkt_o
);
  import hrlp_pkg::*;

  localparam int MaxCap0 = (METHOD_CAPACITY > PROTOCOL_CAPACITY) ?
                           METHOD_CAPACITY : PROTOCOL_CAPACITY;
  localparam int MaxCap  = (TARGET_CAPACITY > MaxCap0) ? TARGET_CAPACITY : MaxCap0;
  localparam int PosW    = $clog2(MaxCap);
  localparam logic [PosW-1:0] MethodLim   = PosW'(METHOD_CAPACITY - 1);
  localparam logic [PosW-1:0] TargetLim   = PosW'(TARGET_CAPACITY - 1);
  localparam logic [PosW-1:0] ProtocolLim = PosW'(PROTOCOL_CAPACITY - 1);

  // Parse phases
  localparam logic [2:0] PH_METHOD  = 3'd0;
  localparam logic [2:0] PH_TARGET  = 3'd1;
  localparam logic [2:0] PH_PROTO   = 3'd2;
  localparam logic [2:0] PH_VERSION = 3'd3;
  localparam logic [2:0] PH_NAME    = 3'd4;
  localparam logic [2:0] PH_VALUE   = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  // Version conversion phases
  localparam logic [1:0] NUM_INT  = 2'd0;
  localparam logic [1:0] NUM_FRAC = 2'd1;
  localparam logic [1:0] NUM_STOP = 2'd3;

  typedef struct packed {
    logic [1:0] np;
    logic [7:0] maj;
    logic [3:0] ten;
  } ver_t;

  logic [2:0]      phase_q, phase_d;
  logic [PosW-1:0] wpos_q, wpos_d;
  logic            crp_q, crp_d;
  logic [7:0]      major_q, major_d;
  logic [3:0]      tenths_q, tenths_d;
  logic [1:0]      nphase_q, nphase_d;
  logic            fin;
  logic            do_normal;
  logic [7:0]      c;
  ver_t            ver;

  // One character into the version converter
  function automatic ver_t feed(input ver_t v, input logic [7:0] ch);
    ver_t        r;
    logic        dig;
    logic [11:0] acc;
    r   = v;
    dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
    acc = {1'b0, v.maj, 3'b000} + {3'b000, v.maj, 1'b0} + {8'h00, 4'(ch - CH_ZERO)};
    if (v.np == NUM_INT) begin
      if (dig) begin
        r.maj = (acc > 12'd255) ? 8'd255 : acc[7:0];
      end else if (ch == CH_DOT) begin
        r.np = NUM_FRAC;
      end else begin
        r.np = NUM_STOP;
      end
    end else if (v.np == NUM_FRAC) begin
      if (dig) begin
        r.ten = 4'(ch - CH_ZERO);
      end
      r.np = NUM_STOP;
    end
    return r;
  endfunction

  assign c = req_i.data_byte;

  // Next parse state and packet for the byte on the input
  always_comb begin
    phase_d   = req_i.first ? PH_METHOD : phase_q;
    wpos_d    = req_i.first ? '0 : wpos_q;
    crp_d     = req_i.first ? 1'b0 : crp_q;
    major_d   = req_i.first ? 8'd0 : major_q;
    tenths_d  = req_i.first ? 4'd0 : tenths_q;
    nphase_d  = req_i.first ? NUM_INT : nphase_q;
    pkt_o     = '0;
    fin       = req_i.final_byte || (c == CH_NUL);
    do_normal = 1'b0;
    ver       = '0;

    if (phase_d != PH_DONE) begin
      if (c != CH_NUL) begin
        do_normal = 1'b1;
        // Held CR: either the CR LF pair, or a CR that becomes ordinary
        if (crp_d) begin
          crp_d = 1'b0;
          if (c == CH_LF) begin
            do_normal = 1'b0;
            if (phase_d == PH_VERSION) begin
              pkt_o.has_main = 1'b1;
              pkt_o.kind     = KIND_VERSION;
              pkt_o.major    = major_d;
              pkt_o.tenths   = tenths_d;
              phase_d        = PH_NAME;
              wpos_d         = '0;
            end else if (phase_d == PH_NAME) begin
              pkt_o.has_main = 1'b1;
              pkt_o.kind     = KIND_BLANK;
              phase_d        = PH_DONE;
            end else begin
              phase_d = PH_NAME;
              wpos_d  = '0;
            end
          end else if (phase_d == PH_VERSION) begin
            ver = feed({nphase_d, major_d, tenths_d}, CH_CR);
            {nphase_d, major_d, tenths_d} = ver;
          end
        end

        // The byte itself
        if (do_normal) begin
          if (phase_d >= PH_VERSION && phase_d <= PH_VALUE && c == CH_CR) begin
            crp_d = 1'b1;
          end else begin
            unique case (phase_d)
              PH_METHOD: begin
                if (c == CH_SPACE) begin
                  phase_d = PH_TARGET;
                  wpos_d  = '0;
                end else if (wpos_d < MethodLim) begin
                  pkt_o.has_main = 1'b1;
                  pkt_o.kind     = KIND_METHOD;
                  pkt_o.position = 7'(wpos_d);
                  pkt_o.char_raw = c;
                  wpos_d         = wpos_d + 1'b1;
                end
              end
              PH_TARGET: begin
                if (c == CH_SPACE) begin
                  phase_d = PH_PROTO;
                  wpos_d  = '0;
                end else if (wpos_d < TargetLim) begin
                  pkt_o.has_main = 1'b1;
                  pkt_o.kind     = KIND_TARGET;
                  pkt_o.position = 7'(wpos_d);
                  pkt_o.char_raw = c;
                  wpos_d         = wpos_d + 1'b1;
                end
              end
              PH_PROTO: begin
                if (c == CH_SLASH) begin
                  phase_d  = PH_VERSION;
                  wpos_d   = '0;
                  major_d  = 8'd0;
                  tenths_d = 4'd0;
                  nphase_d = NUM_INT;
                end else if (wpos_d < ProtocolLim) begin
                  pkt_o.has_main = 1'b1;
                  pkt_o.kind     = KIND_PROTOCOL;
                  pkt_o.position = 7'(wpos_d);
                  pkt_o.char_raw = c;
                  wpos_d         = wpos_d + 1'b1;
                end
              end
              PH_VERSION: begin
                ver = feed({nphase_d, major_d, tenths_d}, c);
                {nphase_d, major_d, tenths_d} = ver;
              end
              PH_NAME: begin
                if (c == CH_COLON) begin
                  phase_d = PH_VALUE;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end

      // End of text: flush a held CR, then report and finish
      if (fin && phase_d != PH_DONE) begin
        if (crp_d) begin
          crp_d = 1'b0;
          if (phase_d == PH_VERSION) begin
            nphase_d = NUM_STOP;
          end
        end
        pkt_o.has_end = 1'b1;
        phase_d       = PH_DONE;
      end
    end
  end

  assign enq_o = accept_i && (pkt_o.has_main || pkt_o.has_end);

  // Parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_METHOD;
      wpos_q   <= '0;
      crp_q    <= 1'b0;
      major_q  <= 8'd0;
      tenths_q <= 4'd0;
      nphase_q <= NUM_INT;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      wpos_q   <= wpos_d;
      crp_q    <= crp_d;
      major_q  <= major_d;
      tenths_q <= tenths_d;
      nphase_q <= nphase_d;
    end
  end

endmodule

FILE: hw/rtl/hrlp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlp_queue: packet queue between front and back
// Small register FIFO; the head entry is visible while not empty.
// ----------------------------------------------------------------------------
module hrlp_queue #(
  parameter int DEPTH = hrlp_pkg::HRLP_QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  hrlp_pkg::hrlp_pkt_t wr_data_i,
  input  logic              rd_en_i,
  output hrlp_pkg::hrlp_pkt_t rd_data_o,
  output logic              full_o,
  output logic              empty_o
);
  import hrlp_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  hrlp_pkt_t       mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      end
      if (wr_en_i && !rd_en_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!wr_en_i && rd_en_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/hrlp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlp_back: result sequencer
// Expands each packet into one or two results, lower-cases method and
// protocol characters and marks the last result of each byte.
// ----------------------------------------------------------------------------
module hrlp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hrlp_pkg::hrlp_pkt_t head_i,
  input  logic              head_empty_i,
  output logic              deq_o,
  input  logic              pop_i,
  output logic              empty_o,
  output hrlp_pkg::hrlp_res_t res_o
);
  import hrlp_pkg::*;

  logic sub_q, sub_d;
  logic show_end;
  logic take;
  logic fold;

  assign empty_o  = head_empty_i;
  assign show_end = sub_q || !head_i.has_main;
  assign take     = pop_i && !head_empty_i;
  assign deq_o    = take && (show_end || !head_i.has_end);
  assign fold     = (head_i.kind == KIND_METHOD) || (head_i.kind == KIND_PROTOCOL);

  // Result formatting
  always_comb begin
    res_o = '0;
    if (show_end) begin
      res_o.kind = KIND_END;
      res_o.last = 1'b1;
    end else begin
      res_o.kind           = head_i.kind;
      res_o.position       = head_i.position;
      res_o.char_out       = head_i.char_raw;
      res_o.version_major  = head_i.major;
      res_o.version_tenths = head_i.tenths;
      res_o.last           = !head_i.has_end;
      if (fold && head_i.char_raw >= 8'h41 && head_i.char_raw <= 8'h5A) begin
        res_o.char_out = head_i.char_raw + 8'h20;
      end
    end
  end

  // Second-result flag for packets that carry two results
  always_comb begin
    sub_d = sub_q;
    if (take) begin
      sub_d = !show_end && head_i.has_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
    end else begin
      sub_q <= sub_d;
    end
  end

endmodule

FILE: hw/rtl/http_request_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_line_parser: HTTP request line splitter
// Splits the request line into method, target and protocol characters and
// reports the protocol version, a blank line and the end of the text.
//
//   Channel   Handshake          Payload
//   request   push / full        req_i  (data_byte, first, final_byte)
//   result    empty / pop        res_o  (kind, position, char_out,
//                                        version_major, version_tenths, last)
//
// A byte is taken in every cycle while full is low; the parse state updates
// in that same cycle, so consecutive bytes need no gap.
// A byte's first result is queued and shows once older results have left.
// Bytes without results use no queue entry.
// Results leave one per cycle; a byte causing two results holds its queue
// entry for two pops, so a run of such bytes, or a stalled result side,
// fills the packet queue (QUEUE_DEPTH entries) and raises full.
// Reset clears the parse state and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module http_request_line_parser #(
  parameter int METHOD_CAPACITY   = hrlp_pkg::HRLP_METHOD_CAP,
  parameter int TARGET_CAPACITY   = hrlp_pkg::HRLP_TARGET_CAP,
  parameter int PROTOCOL_CAPACITY = hrlp_pkg::HRLP_PROTOCOL_CAP,
  parameter int QUEUE_DEPTH       = hrlp_pkg::HRLP_QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  hrlp_pkg::hrlp_req_t req_i,
  output logic              empty,
  input  logic              pop,
  output hrlp_pkg::hrlp_res_t res_o
);
  import hrlp_pkg::*;

  logic      accept;
  logic      enq;
  logic      deq;
  logic      q_empty;
  hrlp_pkt_t enq_pkt;
  hrlp_pkt_t head_pkt;

  assign accept = push && !full;

  // Front: classify bytes and keep parse state
  hrlp_front #(
    .METHOD_CAPACITY  (METHOD_CAPACITY),
    .TARGET_CAPACITY  (TARGET_CAPACITY),
    .PROTOCOL_CAPACITY(PROTOCOL_CAPACITY)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .req_i   (req_i),
    .enq_o   (enq),
    .pkt_o   (enq_pkt)
  );

  // Packet queue
  hrlp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (enq),
    .wr_data_i(enq_pkt),
    .rd_en_i  (deq),
    .rd_data_o(head_pkt),
    .full_o   (full),
    .empty_o  (q_empty)
  );

  // Back: result sequencing
  hrlp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_pkt),
    .head_empty_i(q_empty),
    .deq_o       (deq),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res_o)
  );

endmodule

FILE: hw/rtl/hrlp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlp_checker: port-level checks of the request line parser
// Watches the result channel for holding, pairing and field rules.
// ----------------------------------------------------------------------------
module hrlp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              push,
  input logic              full,
  input hrlp_pkg::hrlp_req_t req_i,
  input logic              empty,
  input logic              pop,
  input hrlp_pkg::hrlp_res_t res_o
);
  import hrlp_pkg::*;

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_o)))
    else $error("result changed while waiting");

  // A non-last result is always followed by the text-ended result
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !res_o.last) |=> (!empty && res_o.kind == KIND_END))
    else $error("second result of a byte missing");

  // Blank line and text end close their byte
  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (res_o.kind == KIND_END || res_o.kind == KIND_BLANK)) |-> res_o.last)
    else $error("terminal result not marked last");

  // Version fields only on version results
  a_ver_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.kind != KIND_VERSION) |->
      (res_o.version_major == 8'd0 && res_o.version_tenths == 4'd0))
    else $error("version fields set on a non-version result");

  // No character data on non-character results
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (res_o.kind == KIND_VERSION || res_o.kind == KIND_BLANK ||
                res_o.kind == KIND_END)) |->
      (res_o.position == 7'd0 && res_o.char_out == 8'd0))
    else $error("character fields set on a non-character result");

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker (.*);
